>>> hdl/rlec_pkg.sv
package rlec_pkg;

	localparam int ENTRIES = 64;
	localparam int LANES   = 8;
	localparam int ROWS    = ENTRIES / LANES;
	localparam int SLOT_W  = $clog2(ENTRIES);
	localparam int LANE_W  = $clog2(LANES);
	localparam int ROW_W   = SLOT_W - LANE_W;
	localparam int PTR_W   = SLOT_W + 1;
	localparam int DEV_W   = 2;
	localparam int OBJ_W   = 32;
	localparam int KEY_W   = DEV_W + OBJ_W;
	localparam int CNT_W   = 16;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);

	localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

	typedef enum logic [1:0] {
		OP_GET  = 2'd0,
		OP_REL  = 2'd1,
		OP_DUP  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_NOREF = 2'd2,
		ST_SAT   = 2'd3
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [SLOT_W-1:0] slot;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic              hit;
		logic              evicted;
		logic [DEV_W-1:0]  ev_dev;
		logic [OBJ_W-1:0]  ev_num;
		logic [CNT_W-1:0]  cnt;
	} res_t;

	function automatic logic is_nil(input logic [PTR_W-1:0] p);
		return p[PTR_W-1];
	endfunction

endpackage

>>> hdl/rlec_front.sv
module rlec_front import rlec_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        op,
	input  logic [DEV_W-1:0]  device,
	input  logic [OBJ_W-1:0]  object_number,
	input  logic [SLOT_W-1:0] slot,
	output logic              q_valid,
	output req_t              q_data,
	input  logic              q_pop
);

	req_t              buf_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;
	req_t              req_d;
	logic              wr, rd;

	always_comb begin
		req_d.op   = op_t'(op);
		req_d.key  = {device, object_number};
		req_d.slot = slot;
	end

	assign full    = (cnt_q == (QPTR_W + 1)'(QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_data  = buf_q[rp_q];
	assign wr      = push && !full;
	assign rd      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			buf_q[wp_q] <= req_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/rlec_back.sv
module rlec_back import rlec_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  req_t q_data,
	output logic q_pop,
	output logic res_valid,
	output res_t res,
	input  logic res_pop
);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_EVA, S_EVK, S_RDC, S_CNT, S_PUSH
	} state_t;

	state_t            state_q;
	req_t              req_q;
	logic [SLOT_W-1:0] s_q;
	logic [ROW_W-1:0]  row_q, cmp_row_q;
	logic              cmp_v_q;
	logic [PTR_W-1:0]  head_q, tail_q, oldhead_q;
	logic [ENTRIES-1:0] used_q;
	logic              res_v_q;
	res_t              res_q;

	logic [KEY_W-1:0]  key_mem [ROWS][LANES];
	logic [KEY_W-1:0]  key_rd_q [LANES];
	logic [CNT_W-1:0]  cnt_mem [ENTRIES];
	logic [CNT_W-1:0]  cnt_rd_q;
	logic [PTR_W-1:0]  prev_mem [ENTRIES];
	logic [PTR_W-1:0]  next_mem [ENTRIES];
	logic [PTR_W-1:0]  prev_rd_q, next_rd_q;

	logic              key_we;
	logic [SLOT_W-1:0] key_wa;
	logic [ROW_W-1:0]  key_ra;
	logic              cnt_we;
	logic [CNT_W-1:0]  cnt_wd;
	logic [SLOT_W-1:0] cnt_wa;
	logic              nx_we, pv_we;
	logic [SLOT_W-1:0] nx_wa, pv_wa;
	logic [PTR_W-1:0]  nx_wd, pv_wd;

	logic              hit_any;
	logic [LANE_W-1:0] hit_lane;
	logic              free_any;
	logic [SLOT_W-1:0] free_slot;
	logic              fin, ul, push_hd, alloc;
	res_t              res_d;
	logic [KEY_W-1:0]  ev_key;
	logic              c_max, c_zero;

	assign c_max  = &cnt_rd_q;
	assign c_zero = (cnt_rd_q == '0);
	assign ev_key = key_rd_q[s_q[LANE_W-1:0]];
	assign key_ra = (state_q == S_SCAN) ? row_q : s_q[SLOT_W-1:LANE_W];

	// lowest matching lane in the row under compare
	always_comb begin
		hit_any  = 1'b0;
		hit_lane = '0;
		for (int l = LANES - 1; l >= 0; l--) begin
			if (used_q[{cmp_row_q, LANE_W'(l)}] && key_rd_q[l] == req_q.key) begin
				hit_any  = 1'b1;
				hit_lane = LANE_W'(l);
			end
		end
	end

	always_comb begin
		free_any  = 1'b0;
		free_slot = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_any  = 1'b1;
				free_slot = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		fin     = 1'b0;
		ul      = 1'b0;
		push_hd = 1'b0;
		alloc   = 1'b0;
		res_d   = '0;
		key_we  = 1'b0;
		key_wa  = s_q;
		cnt_we  = 1'b0;
		cnt_wa  = s_q;
		cnt_wd  = '0;
		nx_we   = 1'b0;
		nx_wa   = s_q;
		nx_wd   = next_rd_q;
		pv_we   = 1'b0;
		pv_wa   = s_q;
		pv_wd   = prev_rd_q;
		case (state_q)
			S_IDLE: begin
				if (q_valid && !res_v_q) begin
					if (q_data.op == OP_REL || q_data.op == OP_DUP) begin
						if (!used_q[q_data.slot]) begin
							fin          = 1'b1;
							res_d.status = ST_NOREF;
						end
					end else if (q_data.op != OP_GET) begin
						fin = 1'b1;
					end
				end
			end
			S_SCAN: begin
				if (cmp_v_q && !hit_any && cmp_row_q == ROW_W'(ROWS - 1)) begin
					if (free_any) begin
						alloc     = 1'b1;
						key_we    = 1'b1;
						key_wa    = free_slot;
						cnt_we    = 1'b1;
						cnt_wa    = free_slot;
						cnt_wd    = CNT_W'(1);
						fin       = 1'b1;
						res_d.slot = free_slot;
						res_d.cnt  = CNT_W'(1);
					end else if (is_nil(tail_q)) begin
						fin          = 1'b1;
						res_d.status = ST_FULL;
					end
				end
			end
			S_EVK: begin
				ul            = 1'b1;
				key_we        = 1'b1;
				cnt_we        = 1'b1;
				cnt_wd        = CNT_W'(1);
				fin           = 1'b1;
				res_d.slot    = s_q;
				res_d.evicted = 1'b1;
				res_d.ev_dev  = ev_key[KEY_W-1:OBJ_W];
				res_d.ev_num  = ev_key[OBJ_W-1:0];
				res_d.cnt     = CNT_W'(1);
			end
			S_CNT: begin
				fin = 1'b1;
				if (req_q.op == OP_GET) begin
					res_d.hit  = 1'b1;
					res_d.slot = s_q;
				end
				if (req_q.op != OP_GET && c_zero) begin
					res_d.status = ST_NOREF;
				end else if (req_q.op != OP_REL && c_max) begin
					res_d.status = ST_SAT;
					res_d.cnt    = cnt_rd_q;
				end else if (req_q.op == OP_REL) begin
					cnt_we    = 1'b1;
					cnt_wd    = cnt_rd_q - 1'b1;
					res_d.cnt = cnt_rd_q - 1'b1;
					if (cnt_rd_q == CNT_W'(1)) begin
						push_hd = 1'b1;
						nx_we   = 1'b1;
						nx_wd   = head_q;
						pv_we   = 1'b1;
						pv_wd   = NIL;
					end
				end else begin
					ul        = (req_q.op == OP_GET) && c_zero;
					cnt_we    = 1'b1;
					cnt_wd    = cnt_rd_q + 1'b1;
					res_d.cnt = cnt_rd_q + 1'b1;
				end
			end
			S_PUSH: begin
				pv_we = 1'b1;
				pv_wa = oldhead_q[SLOT_W-1:0];
				pv_wd = {1'b0, s_q};
			end
			default: begin
			end
		endcase
		// unlink: next[prev] = next, prev[next] = prev
		if (ul) begin
			nx_we = !is_nil(prev_rd_q);
			nx_wa = prev_rd_q[SLOT_W-1:0];
			nx_wd = next_rd_q;
			pv_we = !is_nil(next_rd_q);
			pv_wa = next_rd_q[SLOT_W-1:0];
			pv_wd = prev_rd_q;
		end
	end

	assign q_pop = (state_q == S_IDLE) && q_valid && !res_v_q;

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_wa[SLOT_W-1:LANE_W]][key_wa[LANE_W-1:0]] <= req_q.key;
		end
		key_rd_q <= key_mem[key_ra];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		cnt_rd_q <= cnt_mem[s_q];
	end

	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_wa] <= nx_wd;
		end
		next_rd_q <= next_mem[s_q];
	end

	always_ff @(posedge clk) begin
		if (pv_we) begin
			prev_mem[pv_wa] <= pv_wd;
		end
		prev_rd_q <= prev_mem[s_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			req_q     <= '0;
			s_q       <= '0;
			row_q     <= '0;
			cmp_row_q <= '0;
			cmp_v_q   <= 1'b0;
			head_q    <= NIL;
			tail_q    <= NIL;
			oldhead_q <= NIL;
			used_q    <= '0;
			res_v_q   <= 1'b0;
			res_q     <= '0;
		end else begin
			if (res_v_q && res_pop) begin
				res_v_q <= 1'b0;
			end
			if (fin) begin
				res_v_q <= 1'b1;
				res_q   <= res_d;
			end
			if (alloc) begin
				used_q[free_slot] <= 1'b1;
				s_q               <= free_slot;
			end
			if (ul) begin
				if (is_nil(prev_rd_q)) begin
					head_q <= next_rd_q;
				end
				if (is_nil(next_rd_q)) begin
					tail_q <= prev_rd_q;
				end
			end
			if (push_hd) begin
				head_q    <= {1'b0, s_q};
				oldhead_q <= head_q;
				if (is_nil(head_q)) begin
					tail_q <= {1'b0, s_q};
				end
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						req_q <= q_data;
						s_q   <= q_data.slot;
						row_q <= '0;
						cmp_v_q <= 1'b0;
						if (q_data.op == OP_GET) begin
							state_q <= S_SCAN;
						end else if (!fin) begin
							state_q <= S_RDC;
						end
					end
				end
				S_SCAN: begin
					row_q     <= row_q + 1'b1;
					cmp_row_q <= row_q;
					cmp_v_q   <= 1'b1;
					if (cmp_v_q && hit_any) begin
						s_q     <= {cmp_row_q, hit_lane};
						state_q <= S_RDC;
					end else if (cmp_v_q && cmp_row_q == ROW_W'(ROWS - 1)) begin
						if (!free_any && !is_nil(tail_q)) begin
							s_q     <= tail_q[SLOT_W-1:0];
							state_q <= S_EVA;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_EVA: state_q <= S_EVK;
				S_EVK: state_q <= S_IDLE;
				S_RDC: state_q <= S_CNT;
				S_CNT: begin
					if (push_hd && !is_nil(head_q)) begin
						state_q <= S_PUSH;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_PUSH: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_v_q;
	assign res       = res_q;

endmodule

>>> hdl/refcounted_lru_entry_cache_top.sv
// A get scans the key memory at 8 lanes per cycle over 8 rows of key memory, then reads
//   the count and updates the free list; a release/dup reads the count, and one for an unused
//   slot, like an unknown op, is answered from the idle state.
// One request at a time is in the engine; the next starts once the result is
//   taken (after a release that relinks the free-list head, also once S_PUSH is done).
// The result register holds one result; requests queue 4 deep in front meanwhile.
// Reset: asynchronous, clears used bits, free-list head/tail and all control state.
module refcounted_lru_entry_cache_top import rlec_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        op,
	input  logic [DEV_W-1:0]  device,
	input  logic [OBJ_W-1:0]  object_number,
	input  logic [SLOT_W-1:0] slot,
	output logic              empty,
	input  logic              pop,
	output logic [1:0]        status,
	output logic [SLOT_W-1:0] slot_out,
	output logic              hit,
	output logic              evicted,
	output logic [DEV_W-1:0]  evicted_device,
	output logic [OBJ_W-1:0]  evicted_number,
	output logic [CNT_W-1:0]  count_after
);

	logic q_valid, q_pop, res_valid;
	req_t q_data;
	res_t res;

	rlec_front u_front (
		.clk, .arst_n, .push, .full, .op, .device, .object_number, .slot,
		.q_valid, .q_data, .q_pop
	);

	rlec_back u_back (
		.clk, .arst_n, .q_valid, .q_data, .q_pop,
		.res_valid, .res, .res_pop(pop)
	);

	assign empty          = !res_valid;
	assign status         = res.status;
	assign slot_out       = res.slot;
	assign hit            = res.hit;
	assign evicted        = res.evicted;
	assign evicted_device = res.ev_dev;
	assign evicted_number = res.ev_num;
	assign count_after    = res.cnt;

endmodule
